// ===== rtl/matrix4x4_multiply_add_scale_transpose_top_assert.svh =====
// Assertion macros for the matrix engine.
`ifndef MATRIX4X4_MULTIPLY_ADD_SCALE_TRANSPOSE_TOP_ASSERT_SVH
`define MATRIX4X4_MULTIPLY_ADD_SCALE_TRANSPOSE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define MMAST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MMAST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMAST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MMAST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/mmast_pkg.sv =====
`timescale 1ns / 1ps
package mmast_pkg;

    localparam int ELEM_W = 32;
    localparam int ACC_W  = 64;

    localparam logic signed [ACC_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT_LO = -64'sd2147483648;

    typedef enum logic [2:0] {
        CMD_WR_A  = 3'd0,
        CMD_WR_B  = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_ADD   = 3'd3,
        CMD_SCALE = 3'd4,
        CMD_TRANS = 3'd5,
        CMD_READ  = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] element;
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic               last;
    } t_rsp;

    typedef struct packed {
        logic v;
        logic first;
        logic last;
    } t_stage_tag;

endpackage

// ===== rtl/mmast_ram.sv =====
`timescale 1ns / 1ps
module mmast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/matrix4x4_multiply_add_scale_transpose_top.sv =====
`timescale 1ns / 1ps
`include "matrix4x4_multiply_add_scale_transpose_top_assert.svh"
// DIM x DIM signed Q16.16 matrix engine holding matrices A and B.
// Request channel: i_req_valid / o_req_stall / i_req. Response channel:
// o_rsp_valid / i_rsp_stall / o_rsp. A transfer happens when valid is high
// and stall is low.
// Element writes (write A, write B) give no response.
// Multiply, add, scale, transpose and read run through one shared
// multiply-accumulate pipeline into a scratch buffer, then stream A out in
// row-major order with last set on the final element.
// For DIM = 4, multiply issues DIM^3 = 64 MAC steps and the elementwise
// commands issue DIM^2 = 16 steps; the pipeline then drains, and each
// element is read from the scratch buffer (registered read) and then
// loaded into the output register. o_req_stall stays high from the
// accepting edge of a compute request until its last element has been
// loaded into the output register.
// A stalled response holds in the output register; the stream waits for it.
// Synchronous active-low reset: both matrices read as zero (valid bits are
// cleared), no response is pending and the block is ready next cycle.
module matrix4x4_multiply_add_scale_transpose_top
    import mmast_pkg::*;
#(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    localparam int CELLS = DIM * DIM;
    localparam int IW    = $clog2(DIM);
    localparam int AW    = $clog2(CELLS);
    localparam logic [IW-1:0] IDX_MAX  = IW'(DIM - 1);
    localparam logic [AW-1:0] CNT_LAST = AW'(CELLS - 1);

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic signed [ELEM_W-1:0] r_scalar;
    logic [IW-1:0] r_i, r_j, r_k;
    logic [CELLS-1:0] r_a_vld, r_b_vld;

    t_stage_tag r_s1_tag, r_s2_tag;
    logic [AW-1:0] r_s1_dest, r_s2_dest, r_s3_dest;
    logic r_s1_av, r_s1_bv, r_s3_wr;
    logic signed [ACC_W-1:0]  r_prod, r_acc;
    logic signed [ELEM_W-1:0] r_opa, r_opb;

    logic [AW-1:0] r_ecnt;
    logic [IW-1:0] r_ei, r_ej;
    logic r_out_valid;
    t_rsp r_out;

    logic req_acc, start_op, wr_a, wr_b, wr_ok, slot_free, rsp_taken;
    logic issue, issue_last, is_mul, emit_rd, emit_ld, emit_last, drained;
    logic [AW-1:0] wr_addr, dest_addr, a_raddr, b_raddr, a_waddr;
    logic [ELEM_W-1:0] a_rdata, b_rdata, t_rdata, a_wdata, t_wdata;
    logic a_we;
    logic signed [ELEM_W-1:0] a_val, b_val, mul_rhs;
    logic signed [ACC_W-1:0]  shifted, add_l, add_r;

    assign o_req_stall = (r_state != ST_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign rsp_taken   = r_out_valid && !i_rsp_stall;
    assign slot_free   = !r_out_valid || !i_rsp_stall;

    assign wr_ok   = ({30'd0, i_req.row} < 32'(DIM)) && ({30'd0, i_req.col} < 32'(DIM));
    assign wr_addr = AW'(32'(i_req.row) * DIM + 32'(i_req.col));
    assign wr_a    = req_acc && (i_req.command == CMD_WR_A) && wr_ok;
    assign wr_b    = req_acc && (i_req.command == CMD_WR_B) && wr_ok;

    always_comb begin
        case (i_req.command)
            CMD_MUL, CMD_ADD, CMD_SCALE, CMD_TRANS, CMD_READ: start_op = req_acc;
            default:                                          start_op = 1'b0;
        endcase
    end

    assign is_mul     = (r_cmd == CMD_MUL);
    assign issue_last = (r_i == IDX_MAX) && (r_j == IDX_MAX) && (!is_mul || r_k == IDX_MAX);
    assign emit_last  = (r_ecnt == CNT_LAST);
    assign drained    = !r_s1_tag.v && !r_s2_tag.v && !r_s3_wr;

    assign dest_addr = AW'(32'(r_i) * DIM + 32'(r_j));
    always_comb begin
        if (is_mul) begin
            a_raddr = AW'(32'(r_i) * DIM + 32'(r_k));
            b_raddr = AW'(32'(r_k) * DIM + 32'(r_j));
        end else if (r_cmd == CMD_TRANS) begin
            a_raddr = AW'(32'(r_j) * DIM + 32'(r_i));
            b_raddr = dest_addr;
        end else begin
            a_raddr = dest_addr;
            b_raddr = dest_addr;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (start_op) n_state = ST_COMP;
            ST_COMP:    if (issue_last) n_state = ST_DRAIN;
            ST_DRAIN:   if (drained) n_state = ST_EMIT_RD;
            ST_EMIT_RD: n_state = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (slot_free) n_state = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        issue   = 1'b0;
        emit_rd = 1'b0;
        emit_ld = 1'b0;
        case (r_state)
            ST_COMP:    issue   = 1'b1;
            ST_EMIT_RD: emit_rd = 1'b1;
            ST_EMIT_LD: emit_ld = slot_free;
            default:    ;
        endcase
    end

    assign a_we    = wr_a || emit_ld;
    assign a_waddr = emit_ld ? r_ecnt : wr_addr;
    assign a_wdata = emit_ld ? t_rdata : i_req.value;

    mmast_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_ram_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_re(issue), .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    mmast_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_ram_b (
        .i_clk(i_clk), .i_we(wr_b), .i_waddr(wr_addr), .i_wdata(i_req.value),
        .i_re(issue), .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    mmast_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_ram_t (
        .i_clk(i_clk), .i_we(r_s3_wr), .i_waddr(r_s3_dest), .i_wdata(t_wdata),
        .i_re(emit_rd), .i_raddr(r_ecnt), .o_rdata(t_rdata)
    );

    // stage 1: multiply
    assign a_val   = r_s1_av ? signed'(a_rdata) : '0;
    assign b_val   = r_s1_bv ? signed'(b_rdata) : '0;
    assign mul_rhs = (r_cmd == CMD_SCALE) ? r_scalar : b_val;

    // stage 2: shift and add
    assign shifted = r_prod >>> FRAC_BITS;
    always_comb begin
        case (r_cmd)
            CMD_MUL: begin
                add_l = r_s2_tag.first ? '0 : r_acc;
                add_r = shifted;
            end
            CMD_SCALE: begin
                add_l = '0;
                add_r = shifted;
            end
            CMD_ADD: begin
                add_l = ACC_W'(r_opa);
                add_r = ACC_W'(r_opb);
            end
            default: begin
                add_l = ACC_W'(r_opa);
                add_r = '0;
            end
        endcase
    end

    // stage 3: saturate into scratch buffer
    always_comb begin
        if (r_acc > SAT_HI) begin
            t_wdata = SAT_HI[ELEM_W-1:0];
        end else if (r_acc < SAT_LO) begin
            t_wdata = SAT_LO[ELEM_W-1:0];
        end else begin
            t_wdata = r_acc[ELEM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_a_vld     <= '0;
            r_b_vld     <= '0;
            r_s1_tag    <= '0;
            r_s2_tag    <= '0;
            r_s3_wr     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (a_we) begin
                r_a_vld[a_waddr] <= 1'b1;
            end
            if (wr_b) begin
                r_b_vld[wr_addr] <= 1'b1;
            end
            r_s1_tag.v     <= issue;
            r_s1_tag.first <= (r_k == '0);
            r_s1_tag.last  <= !is_mul || (r_k == IDX_MAX);
            r_s2_tag       <= r_s1_tag;
            r_s3_wr        <= r_s2_tag.v && r_s2_tag.last;
            if (emit_ld) begin
                r_out_valid <= 1'b1;
            end else if (rsp_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_op) begin
            r_cmd    <= i_req.command;
            r_scalar <= i_req.value;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_ecnt   <= '0;
            r_ei     <= '0;
            r_ej     <= '0;
        end
        if (issue) begin
            if (is_mul && r_k != IDX_MAX) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= '0;
                if (r_j != IDX_MAX) begin
                    r_j <= r_j + 1'b1;
                end else begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end
            end
        end
        r_s1_dest <= dest_addr;
        r_s1_av   <= r_a_vld[a_raddr];
        r_s1_bv   <= r_b_vld[b_raddr];
        r_s2_dest <= r_s1_dest;
        r_prod    <= ACC_W'(a_val) * ACC_W'(mul_rhs);
        r_opa     <= a_val;
        r_opb     <= b_val;
        r_s3_dest <= r_s2_dest;
        if (r_s2_tag.v) begin
            r_acc <= add_l + add_r;
        end
        if (emit_ld) begin
            r_out.element <= signed'(t_rdata);
            r_out.out_row <= 2'(32'(r_ei));
            r_out.out_col <= 2'(32'(r_ej));
            r_out.last    <= emit_last;
            r_ecnt        <= r_ecnt + 1'b1;
            if (r_ej != IDX_MAX) begin
                r_ej <= r_ej + 1'b1;
            end else begin
                r_ej <= '0;
                r_ei <= r_ei + 1'b1;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    `MMAST_ASSERT_IMP(a_emit_after_drain, i_clk, i_rst_n, r_state == ST_EMIT_RD, drained, "stream started with MAC pipeline busy")
    `MMAST_ASSERT_IMP(a_scratch_wr_window, i_clk, i_rst_n, r_s3_wr, r_state == ST_COMP || r_state == ST_DRAIN, "scratch write outside compute")
    `MMAST_ASSERT_NXT(a_last_step_writes, i_clk, i_rst_n, r_s2_tag.v && r_s2_tag.last, r_s3_wr, "finished sum not written")
    `MMAST_ASSERT_IMP(a_elemwise_single_step, i_clk, i_rst_n, r_state == ST_COMP && !is_mul, r_k == '0, "inner index moved on elementwise command")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import mmast_pkg::*;

    localparam int DIM             = 4;
    localparam int FRAC_BITS       = 16;
    localparam int CELLS           = DIM * DIM;
    localparam int RANDOM_REQUESTS = 145;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 120;
    localparam int MAX_REPORTS     = 50;

    localparam t_cmd CMD_NONE = t_cmd'(3'd7);

    localparam logic signed [31:0] Q_MAX     = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [31:0] Q_NEG_ONE = 32'shffff_0000;
    localparam logic signed [31:0] Q_ULP_NEG = 32'shffff_ffff;

    class matrix_shadow;
        logic signed [31:0] mat_a[CELLS];
        logic signed [31:0] mat_b[CELLS];
        t_rsp               pending_elements[$];
        int                 errors;

        function new();
            foreach (mat_a[i]) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            errors = 0;
        endfunction

        // floor of the Q16.16 product
        function longint fx_product(logic signed [31:0] x, logic signed [31:0] y);
            longint p;
            p = longint'(x) * longint'(y);
            return p >>> FRAC_BITS;
        endfunction

        function logic signed [31:0] saturate(longint v);
            if (v > longint'(Q_MAX))
                return Q_MAX;
            if (v < longint'(Q_MIN))
                return Q_MIN;
            return 32'(v);
        endfunction

        function void apply_request(t_req r);
            logic signed [31:0] nxt[CELLS];
            longint             acc;
            t_rsp               e;
            case (r.command)
                CMD_WR_A: begin
                    mat_a[r.row * DIM + r.col] = r.value;
                    return;
                end
                CMD_WR_B: begin
                    mat_b[r.row * DIM + r.col] = r.value;
                    return;
                end
                CMD_MUL: begin
                    for (int i = 0; i < DIM; i++) begin
                        for (int j = 0; j < DIM; j++) begin
                            acc = 0;
                            for (int k = 0; k < DIM; k++)
                                acc += fx_product(mat_a[i * DIM + k], mat_b[k * DIM + j]);
                            nxt[i * DIM + j] = saturate(acc);
                        end
                    end
                    mat_a = nxt;
                end
                CMD_ADD: begin
                    for (int n = 0; n < CELLS; n++)
                        mat_a[n] = saturate(longint'(mat_a[n]) + longint'(mat_b[n]));
                end
                CMD_SCALE: begin
                    for (int n = 0; n < CELLS; n++)
                        mat_a[n] = saturate(fx_product(mat_a[n], r.value));
                end
                CMD_TRANS: begin
                    for (int i = 0; i < DIM; i++)
                        for (int j = 0; j < DIM; j++)
                            nxt[i * DIM + j] = mat_a[j * DIM + i];
                    mat_a = nxt;
                end
                CMD_READ: begin
                end
                default: return;
            endcase
            for (int n = 0; n < CELLS; n++) begin
                e.element = mat_a[n];
                e.out_row = 2'(n / DIM);
                e.out_col = 2'(n % DIM);
                e.last    = (n == CELLS - 1);
                pending_elements.push_back(e);
            end
        endfunction

        function void check_element(t_rsp got);
            t_rsp want;
            if (pending_elements.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected element: got element %h row %0d col %0d last %0b",
                             $time, got.element, got.out_row, got.out_col, got.last);
                return;
            end
            want = pending_elements.pop_front();
            if (got.element !== want.element || got.out_row !== want.out_row ||
                got.out_col !== want.out_col || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch: expected %h r%0d c%0d l%0b, got %h r%0d c%0d l%0b",
                             $time, want.element, want.out_row, want.out_col, want.last,
                             got.element, got.out_row, got.out_col, got.last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall;
    t_rsp o_rsp;

    matrix_shadow shadow;
    bit           burst_mode;
    bit           rsp_hold_req;

    matrix4x4_multiply_add_scale_transpose_top #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 'h8_0000) - 'h4_0000;
            2: return $urandom_range(0, 'h2_0000) - 'h1_0000;
            default: begin
                case ($urandom_range(0, 5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_ULP_NEG;
                    4: return Q_ONE;
                    default: return Q_NEG_ONE;
                endcase
            end
        endcase
    endfunction

    task automatic issue(t_cmd c, logic [1:0] rw, logic [1:0] cl, logic signed [31:0] v);
        t_req r;
        int   gap;
        r.command = c;
        r.row     = rw;
        r.col     = cl;
        r.value   = v;
        @(negedge i_clk);
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (o_req_stall);
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_req_valid <= 1'b0;
        end
    endtask

    // response side: random stall segments, plus one long hold on request
    initial begin
        int n;
        i_rsp_stall <= 1'b0;
        forever begin
            if (rsp_hold_req) begin
                rsp_hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_rsp_stall <= 1'b1;
                end
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: n = 0;
                5, 6, 7, 8:    n = $urandom_range(1, 3);
                default:       n = $urandom_range(10, 40);
            endcase
            repeat (n) begin
                @(negedge i_clk);
                i_rsp_stall <= 1'b1;
            end
            n = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6);
            repeat (n) begin
                @(negedge i_clk);
                i_rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall)
                shadow.check_element(o_rsp);
            if (i_req_valid && !o_req_stall)
                shadow.apply_request(i_req);
        end
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int   roll;
        t_cmd op;
        shadow       = new();
        burst_mode   = 1'b0;
        rsp_hold_req = 1'b0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(CMD_READ, 2'd0, 2'd0, '0);
        issue(CMD_NONE, 2'd3, 2'd3, random_value());
        issue(CMD_WR_A, 2'd0, 2'd0, Q_MAX);
        issue(CMD_WR_A, 2'd0, 2'd1, Q_MIN);
        issue(CMD_WR_A, 2'd2, 2'd1, Q_ONE);
        issue(CMD_WR_A, 2'd3, 2'd3, Q_ULP_NEG);
        issue(CMD_WR_B, 2'd0, 2'd0, Q_MAX);
        issue(CMD_WR_B, 2'd1, 2'd1, Q_MIN);
        issue(CMD_WR_B, 2'd1, 2'd0, Q_NEG_ONE);
        issue(CMD_WR_B, 2'd3, 2'd3, 32'sh0001_8000);
        issue(CMD_WR_B, 2'd2, 2'd2, random_value());
        issue(CMD_ADD, 2'd0, 2'd0, '0);
        issue(CMD_TRANS, 2'd0, 2'd0, '0);
        issue(CMD_MUL, 2'd0, 2'd0, '0);
        issue(CMD_READ, 2'd3, 2'd3, Q_MAX);
        issue(CMD_SCALE, 2'd0, 2'd0, Q_MIN);
        issue(CMD_WR_A, 2'd3, 2'd2, 32'sd1);
        issue(CMD_WR_A, 2'd1, 2'd2, -32'sd3);
        issue(CMD_SCALE, 2'd0, 2'd0, Q_ULP_NEG);
        issue(CMD_SCALE, 2'd0, 2'd0, Q_MAX);
        issue(CMD_MUL, 2'd0, 2'd0, '0);
        issue(CMD_READ, 2'd0, 2'd0, '0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 30 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 30)
                op = CMD_WR_A;
            else if (roll < 55)
                op = CMD_WR_B;
            else if (roll < 67)
                op = CMD_MUL;
            else if (roll < 76)
                op = CMD_ADD;
            else if (roll < 85)
                op = CMD_SCALE;
            else if (roll < 92)
                op = CMD_TRANS;
            else
                op = CMD_READ;
            if (roll >= 97)
                issue(CMD_NONE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      random_value());
            // long output hold while requests keep coming
            if (n == 40) begin
                rsp_hold_req = 1'b1;
                op = CMD_MUL;
            end
            issue(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), random_value());
        end
        @(negedge i_clk);
        i_req_valid <= 1'b0;

        while (shadow.pending_elements.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (shadow.errors == 0 && shadow.pending_elements.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mmast_pkg.sv
rtl/mmast_ram.sv
rtl/matrix4x4_multiply_add_scale_transpose_top.sv
verif/testbench.sv
